>>> rtl/core/vwsh_pkg.sv
// Constants and helpers shared by the variable-width string hash block.
`default_nettype none

package vwsh_pkg;

   localparam int BYTE_W        = 8;
   localparam int HASH_W        = 64;
   localparam int CNT_W         = 64;
   localparam int BITS_W        = 7;
   localparam int MULT_W        = 20;
   localparam int HALF_W        = HASH_W / 2;
   localparam int LO_PROD_W     = HALF_W + MULT_W;
   localparam int SEED_SHIFT    = 7;
   localparam int MAX_HASH_BITS = 64;

   localparam logic [MULT_W-1:0] HASH_MULT     = MULT_W'(1000003);
   localparam logic [BITS_W-1:0] HASH_BITS_RST = BITS_W'(64);
   localparam logic [BITS_W-1:0] MAX_BITS_CODE = BITS_W'(MAX_HASH_BITS);

   typedef logic [HASH_W-1:0] hash_type;

   // Low "bits" ones, width clamped to MAX_HASH_BITS.
   function automatic hash_type width_mask(input logic [BITS_W-1:0] bits);
      logic [BITS_W-1:0] w;
      hash_type          m;
      w = (bits > MAX_BITS_CODE) ? MAX_BITS_CODE : bits;
      if (w >= BITS_W'(HASH_W)) begin
         m = '1;
      end else begin
         m = ~(hash_type'('1) << w);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/variable_width_string_hash_top.sv
// Variable-width string hash: byte stream in, one masked hash per string out.
// Result path: a last byte goes through the input reg, then the result reg.
// Throughput: one byte per cycle; the per-byte multiply/XOR/mask recurrence
// closes through the running hash register. A last byte waits only while a result stalls.
// Reset: synchronous, active high; clears hash, count and valids, sets the start flag,
// and sets hash_bits to 64.
`default_nettype none

module variable_width_string_hash_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [vwsh_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire                               req_last_byte,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [vwsh_pkg::HASH_W-1:0]       rsp_hash_value,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [vwsh_pkg::BITS_W-1:0]       csr_hash_bits
);
   import vwsh_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // running state
   hash_type          hash_ff,  hash_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              start_ff, start_in;
   logic [BITS_W-1:0] bits_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   hash_type          out_hash_ff,  out_hash_in;

   logic                 advance;
   hash_type             hash_src;
   logic [LO_PROD_W-1:0] lo_prod;
   logic [HALF_W-1:0]    hi_prod;
   hash_type             product;
   hash_type             hash_next;
   logic [CNT_W-1:0]     count_next;

   // item moves out of the input register unless its result has nowhere to go
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      hash_src = start_ff ? (hash_type'(in_byte_ff) << SEED_SHIFT) : hash_ff;
      // 64x20 constant product mod 2^64, split in two 32-bit halves
      lo_prod  = LO_PROD_W'(hash_src[HALF_W-1:0]) * LO_PROD_W'(HASH_MULT);
      hi_prod  = hash_src[HASH_W-1:HALF_W] * HALF_W'(HASH_MULT);
      product  = hash_type'(lo_prod) + {hi_prod, HALF_W'(0)};
      hash_next  = (product ^ hash_type'(in_byte_ff)) & width_mask(bits_ff);
      count_next = count_ff + CNT_W'(1);

      hash_in      = hash_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_hash_in  = out_hash_ff;
      if (advance) begin
         if (in_last_ff) begin
            hash_in      = '0;
            count_in     = '0;
            start_in     = 1'b1;
            out_valid_in = 1'b1;
            out_hash_in  = hash_next ^ count_next;
         end else begin
            hash_in  = hash_next;
            count_in = count_next;
            start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         hash_ff      <= '0;
         count_ff     <= '0;
         start_ff     <= 1'b1;
         bits_ff      <= HASH_BITS_RST;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            bits_ff <= csr_hash_bits;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      out_hash_ff <= out_hash_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

endmodule

`default_nettype wire

>>> rtl/core/vwsh_checker.sv
// Port-level assertions for the string hash top level, with its bind.
`default_nettype none

module vwsh_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire  [vwsh_pkg::BYTE_W-1:0]       req_data_byte,
   input wire                               req_last_byte,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire  [vwsh_pkg::HASH_W-1:0]       rsp_hash_value,
   input wire                               csr_valid,
   input wire                               csr_ready,
   input wire  [vwsh_pkg::BITS_W-1:0]       csr_hash_bits
);
   import vwsh_pkg::*;

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed while stalled");

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte)
                                  && $stable(req_last_byte))
      else $error("request changed while waiting");

   // a waiting register write keeps its data
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !csr_ready |=> csr_valid && $stable(csr_hash_bits))
      else $error("register write changed while waiting");

   // a fresh result follows an accepted last-byte request through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte, 2))
      else $error("result without a last-byte request");

   // out of reset: no result pending, request side open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind variable_width_string_hash_top vwsh_checker u_vwsh_checker (.*);

`default_nettype wire

>>> tb/sv/vwsh_hash_monitor.sv
// Checker for the string hash block: tracks requests, predicts each hash and compares results.
`timescale 1ns / 100ps

module vwsh_hash_monitor (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_ready,
   input  wire  [vwsh_pkg::BYTE_W-1:0]  req_data_byte,
   input  wire                          req_last_byte,
   input  wire                          rsp_valid,
   input  wire                          rsp_ready,
   input  wire  [vwsh_pkg::HASH_W-1:0]  rsp_hash_value,
   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  wire  [vwsh_pkg::BITS_W-1:0]  csr_hash_bits,
   input  wire                          drain_check,
   output int                           pending_digests,
   output int                           mismatch_count
);
   import vwsh_pkg::*;

   localparam hash_type          PRIME       = 64'd1000003;
   localparam logic [BITS_W-1:0] WIDTH_AT_RST = 7'd64;

   logic [BITS_W-1:0] width_setting;
   hash_type          running_hash;
   logic [CNT_W-1:0]  string_len;
   logic              string_start;
   logic              leftovers_checked;
   hash_type          expected_digests[$];

   // Widths past 64 saturate, zero width clears the hash entirely.
   function automatic hash_type width_ones(input logic [BITS_W-1:0] bits);
      int w;
      w = (bits > 7'd64) ? 64 : int'(bits);
      if (w == 64) begin
         return '1;
      end
      return (hash_type'(1) << w) - hash_type'(1);
   endfunction

   task automatic report_mismatch(input string what, input hash_type want, input hash_type got);
      $display("ERROR %0t: %s expected %h got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : track
      hash_type h;
      hash_type want;
      if (reset) begin
         width_setting     = WIDTH_AT_RST;
         running_hash      = '0;
         string_len        = '0;
         string_start      = 1'b1;
         leftovers_checked = 1'b0;
         expected_digests.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            width_setting = csr_hash_bits;
         end
         if (req_valid && req_ready) begin
            h = string_start ? (hash_type'(req_data_byte) << SEED_SHIFT) : running_hash;
            h = ((h * PRIME) ^ hash_type'(req_data_byte)) & width_ones(width_setting);
            string_len   = string_len + 1'b1;
            string_start = 1'b0;
            if (req_last_byte) begin
               // length goes in unmasked
               expected_digests.push_back(h ^ string_len);
               h            = '0;
               string_len   = '0;
               string_start = 1'b1;
            end
            running_hash = h;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               report_mismatch("unexpected result, hash_value", '0, rsp_hash_value);
            end else begin
               want = expected_digests.pop_front();
               if (want !== rsp_hash_value) begin
                  report_mismatch("hash_value", want, rsp_hash_value);
               end
            end
         end
         if (drain_check && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_digests.size() != 0) begin
               report_mismatch("missing results, first hash_value", expected_digests[0], '0);
            end
         end
      end
      pending_digests = expected_digests.size();
   end

endmodule

>>> tb/sv/variable_width_string_hash_top_test.sv
// Testbench top for the string hash block: request/config stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module variable_width_string_hash_top_test;
   import vwsh_pkg::*;

   localparam int ITEM_TARGET   = 1050;
   localparam int QUIET_TAIL    = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   // Longest correct stretch without any handshake is the long receiver hold
   // plus a burst or two; the limit is about ten times that.
   localparam int STALL_LIMIT   = 3000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte;
   logic              req_last_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [HASH_W-1:0] rsp_hash_value;
   logic              csr_valid;
   logic              csr_ready;
   logic [BITS_W-1:0] csr_hash_bits;
   logic              drain_check;

   int pending_digests;
   int mismatch_count;
   int bytes_sent;
   int strings_sent;
   int widths_written;
   int idle_pct;
   int random_goal;
   bit quiet_tail;
   bit long_hold_req;

   variable_width_string_hash_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_hash_bits  (csr_hash_bits)
   );

   vwsh_hash_monitor hash_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hash_value  (rsp_hash_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_bits   (csr_hash_bits),
      .drain_check     (drain_check),
      .pending_digests (pending_digests),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Receiver: random stall bursts, one long hold on request, none in the tail.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready    <= 1'b0;
            stall_left    = HOLD_CYCLES - 1;
         end else if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [BITS_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return BITS_W'($urandom_range(65, 127));
         default: return BITS_W'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic int pick_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(13, 48);
      end
      return $urandom_range(1, 12);
   endfunction

   // Called at a falling edge; returns at a falling edge after the accept.
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_data_byte <= b;
      req_last_byte <= last;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
      if (last) begin
         strings_sent++;
      end
      quiet_tail = (bytes_sent + QUIET_TAIL >= random_goal);
      if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic push_bytes(input int count, input logic ends_string);
      for (int i = 0; i < count; i++) begin
         push_byte(pick_byte(), ends_string && (i == count - 1));
      end
   endtask

   // Only while idle: all results in, then enough cycles for a byte in flight.
   task automatic set_width(input logic [BITS_W-1:0] bits);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_digests != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_hash_bits <= bits;
      csr_valid     <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      widths_written++;
   endtask

   initial begin : stimulus
      int  len;
      int  head;
      bit  pressure_done;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_last_byte  = 1'b0;
      csr_valid      = 1'b0;
      csr_hash_bits  = '0;
      drain_check    = 1'b0;
      quiet_tail     = 1'b0;
      long_hold_req  = 1'b0;
      idle_pct       = 0;
      bytes_sent     = 0;
      strings_sent   = 0;
      widths_written = 0;
      random_goal    = 32'h7fff_ffff;
      pressure_done  = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset width, field extremes
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b1);
      set_width(7'd1);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b1);
      // zero width: result is the length alone
      set_width(7'd0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7F, 1'b1);
      // oversize widths saturate
      set_width(7'd127);
      push_byte(8'h3C, 1'b0);
      push_byte(8'hC3, 1'b1);
      set_width(7'd65);
      push_byte(8'hFF, 1'b1);
      // width changes inside one string
      set_width(7'd32);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      set_width(7'd8);
      push_byte(8'hFE, 1'b0);
      set_width(7'd63);
      push_byte(8'h01, 1'b1);
      set_width(7'd64);
      push_byte(8'h55, 1'b1);

      random_goal = bytes_sent + ITEM_TARGET;
      while (bytes_sent < random_goal) begin
         if (!pressure_done && bytes_sent >= random_goal - ITEM_TARGET / 2) begin
            // long receiver hold with back-to-back one-byte strings
            pressure_done = 1'b1;
            idle_pct      = 0;
            long_hold_req = 1'b1;
            repeat (40) push_bytes(1, 1'b1);
         end
         set_width(pick_width());
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            2:       idle_pct = 20;
            default: idle_pct = 40;
         endcase
         repeat ($urandom_range(2, 8)) begin
            len = pick_len();
            if (len > 1 && $urandom_range(0, 7) == 0) begin
               head = $urandom_range(1, len - 1);
               push_bytes(head, 1'b0);
               set_width(pick_width());
               push_bytes(len - head, 1'b1);
            end else begin
               push_bytes(len, 1'b1);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_digests != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      drain_check <= 1'b1;
      repeat (2) @(negedge clock);
      $display("Covered %0d strings of %0d bytes over %0d width writes",
               strings_sent, bytes_sent, widths_written);
      $display("(0, 1, 64, oversize, mid-string); random stalls on both sides");
      $display("plus one %0d-cycle receiver hold with input backpressure.", HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
